// ----- sv/rldm_pkg.sv -----
// rldm_pkg: widths, register indexes and the configuration struct of the radial lens map
// shared by every module of the block; depends on nothing
package rldm_pkg;

   // field and register widths
   localparam int PIX_W      = 16;
   localparam int K_W        = 32;
   localparam int CENTRE_W   = 16;
   localparam int CENTRE_FRAC = 4;
   localparam int SHIFT_W    = 22;
   localparam int SCALE_W    = 20;
   localparam int SCALE_FRAC = 16;
   localparam int OUT_W      = 24;

   // internal datapath widths, sized for the widest coordinate the block supports
   localparam int PROD_W     = PIX_W + SCALE_W;
   localparam int ROUND_LSB  = 8;
   localparam int POS_W      = 30;
   localparam int DMAG_W     = 29;
   localparam int SQ_W       = 2 * DMAG_W;
   localparam int R2_W       = SQ_W + 1;
   localparam int R2_FRAC    = 16;
   localparam int A_W        = DMAG_W + K_W;
   localparam int FULL_W     = A_W + R2_W;
   localparam int SPLIT      = 31;
   localparam int MAG_W      = 33;
   localparam int SUM_W      = 35;

   // configuration port
   localparam int DATA_W     = 32;
   localparam int ADDR_W     = 5;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_K            = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_CENTRE_X     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_CENTRE_Y     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SCALE_ENABLE = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_X_SHIFT      = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_Y_SHIFT      = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_X_SCALE      = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_Y_SCALE      = 3'd7;

   localparam logic [SCALE_W-1:0] SCALE_ONE = 20'd65536;

   // pipeline depth of each part
   localparam int FRONT_STAGES = 4;
   localparam int CORE_STAGES  = 2;
   localparam int MOVE_STAGES  = 6;
   localparam int PIPE_STAGES  = FRONT_STAGES + CORE_STAGES + MOVE_STAGES;

   typedef struct packed {
      logic signed [K_W-1:0]     k;
      logic [CENTRE_W-1:0]       centre_x;
      logic [CENTRE_W-1:0]       centre_y;
      logic                      scale_enable;
      logic signed [SHIFT_W-1:0] x_shift;
      logic signed [SHIFT_W-1:0] y_shift;
      logic [SCALE_W-1:0]        x_scale;
      logic [SCALE_W-1:0]        y_scale;
   } cfg_type;

endpackage

// ----- sv/rldm_csr.sv -----
// rldm_csr: APB-style register file holding the distortion configuration
// uses rldm_pkg for widths, register indexes and cfg_type
module rldm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rldm_pkg::ADDR_W-1:0]   paddr,
   input  logic [rldm_pkg::DATA_W-1:0]   pwdata,
   output logic [rldm_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output rldm_pkg::cfg_type             cfg
);

   localparam int DATA_W    = rldm_pkg::DATA_W;
   localparam int ADDR_W    = rldm_pkg::ADDR_W;
   localparam int K_W       = rldm_pkg::K_W;
   localparam int CENTRE_W  = rldm_pkg::CENTRE_W;
   localparam int SHIFT_W   = rldm_pkg::SHIFT_W;
   localparam int SCALE_W   = rldm_pkg::SCALE_W;

   rldm_pkg::cfg_type cfg_ff;
   rldm_pkg::cfg_type cfg_in;
   logic [rldm_pkg::REG_IDX_W-1:0] reg_idx;
   logic wr_en;

   assign reg_idx = paddr[ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            rldm_pkg::REG_K:            cfg_in.k            = pwdata[K_W-1:0];
            rldm_pkg::REG_CENTRE_X:     cfg_in.centre_x     = pwdata[CENTRE_W-1:0];
            rldm_pkg::REG_CENTRE_Y:     cfg_in.centre_y     = pwdata[CENTRE_W-1:0];
            rldm_pkg::REG_SCALE_ENABLE: cfg_in.scale_enable = pwdata[0];
            rldm_pkg::REG_X_SHIFT:      cfg_in.x_shift      = pwdata[SHIFT_W-1:0];
            rldm_pkg::REG_Y_SHIFT:      cfg_in.y_shift      = pwdata[SHIFT_W-1:0];
            rldm_pkg::REG_X_SCALE:      cfg_in.x_scale      = pwdata[SCALE_W-1:0];
            rldm_pkg::REG_Y_SCALE:      cfg_in.y_scale      = pwdata[SCALE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // register storage, scales reset to unity
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.k            <= '0;
         cfg_ff.centre_x     <= '0;
         cfg_ff.centre_y     <= '0;
         cfg_ff.scale_enable <= 1'b0;
         cfg_ff.x_shift      <= '0;
         cfg_ff.y_shift      <= '0;
         cfg_ff.x_scale      <= rldm_pkg::SCALE_ONE;
         cfg_ff.y_scale      <= rldm_pkg::SCALE_ONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back, signed registers sign-extended
   always_comb begin
      case (reg_idx)
         rldm_pkg::REG_K:            prdata = DATA_W'(cfg_ff.k);
         rldm_pkg::REG_CENTRE_X:     prdata = DATA_W'(cfg_ff.centre_x);
         rldm_pkg::REG_CENTRE_Y:     prdata = DATA_W'(cfg_ff.centre_y);
         rldm_pkg::REG_SCALE_ENABLE: prdata = DATA_W'(cfg_ff.scale_enable);
         rldm_pkg::REG_X_SHIFT:      prdata = DATA_W'(cfg_ff.x_shift);
         rldm_pkg::REG_Y_SHIFT:      prdata = DATA_W'(cfg_ff.y_shift);
         rldm_pkg::REG_X_SCALE:      prdata = DATA_W'(cfg_ff.x_scale);
         rldm_pkg::REG_Y_SCALE:      prdata = DATA_W'(cfg_ff.y_scale);
         default:                    prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/rldm_axis_front.sv -----
// rldm_axis_front: four-stage per-axis front end: optional scale and shift,
// offset from the centre and its magnitude; uses rldm_pkg for widths
module rldm_axis_front (
   input  logic                                clock,
   input  logic                                en,
   input  logic [rldm_pkg::PIX_W-1:0]          pixel,
   input  logic                                scale_en,
   input  logic [rldm_pkg::SCALE_W-1:0]        scale,
   input  logic signed [rldm_pkg::SHIFT_W-1:0] shift,
   input  logic [rldm_pkg::CENTRE_W-1:0]       centre,
   output logic signed [rldm_pkg::POS_W-1:0]   pos,
   output logic [rldm_pkg::DMAG_W-1:0]         dmag,
   output logic                                dneg
);

   localparam int PROD_W    = rldm_pkg::PROD_W;
   localparam int POS_W     = rldm_pkg::POS_W;
   localparam int DMAG_W    = rldm_pkg::DMAG_W;
   localparam int SHIFT_W   = rldm_pkg::SHIFT_W;
   localparam int ROUND_LSB = rldm_pkg::ROUND_LSB;
   localparam int RND_W     = PROD_W - ROUND_LSB;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ROUND_LSB - 1);

   // stage 1: scale product, or the pixel moved to the same binary point
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic signed [SHIFT_W-1:0] shift_ff, shift_in;

   assign prod_in  = scale_en ? PROD_W'(pixel) * PROD_W'(scale)
                              : PROD_W'(pixel) << rldm_pkg::SCALE_FRAC;
   assign shift_in = scale_en ? shift : '0;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         shift_ff <= shift_in;
      end
   end

   // stage 2: round half up to Q.8 and add the shift
   logic [PROD_W-1:0]       rnd_sum;
   logic [RND_W-1:0]        rounded;
   logic signed [POS_W-1:0] pos1_ff, pos1_in;

   assign rnd_sum = prod_ff + ROUND_HALF;
   assign rounded = rnd_sum[PROD_W-1:ROUND_LSB];
   assign pos1_in = signed'(POS_W'(rounded)) + POS_W'(shift_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         pos1_ff <= pos1_in;
      end
   end

   // stage 3: offset from the distortion centre
   logic signed [POS_W-1:0] diff_ff, diff_in;
   logic signed [POS_W-1:0] pos2_ff;

   assign diff_in = pos1_ff - signed'(POS_W'({centre, {rldm_pkg::CENTRE_FRAC{1'b0}}}));

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff <= diff_in;
         pos2_ff <= pos1_ff;
      end
   end

   // stage 4: sign and magnitude of the offset
   logic [DMAG_W-1:0]       dmag_ff, dmag_in;
   logic                    dneg_ff, dneg_in;
   logic signed [POS_W-1:0] pos3_ff;
   logic signed [POS_W-1:0] diff_neg;

   assign diff_neg = -diff_ff;
   assign dneg_in  = diff_ff[POS_W-1];
   assign dmag_in  = dneg_in ? DMAG_W'(diff_neg) : DMAG_W'(diff_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         dmag_ff <= dmag_in;
         dneg_ff <= dneg_in;
         pos3_ff <= pos2_ff;
      end
   end

   assign pos  = pos3_ff;
   assign dmag = dmag_ff;
   assign dneg = dneg_ff;

endmodule

// ----- sv/rldm_axis_move.sv -----
// rldm_axis_move: six-stage per-axis back end: wide product |d|*|k|*r2 from
// four partial products, rounding, clamping, signed move and saturation; uses rldm_pkg
module rldm_axis_move #(
   parameter int K_FRAC_BITS = 40
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic [rldm_pkg::A_W-1:0]           a,
   input  logic [rldm_pkg::R2_W-1:0]          r2,
   input  logic signed [rldm_pkg::POS_W-1:0]  pos,
   input  logic                               neg,
   output logic signed [rldm_pkg::OUT_W-1:0]  mapped,
   output logic                               clip
);

   localparam int A_W     = rldm_pkg::A_W;
   localparam int R2_W    = rldm_pkg::R2_W;
   localparam int POS_W   = rldm_pkg::POS_W;
   localparam int OUT_W   = rldm_pkg::OUT_W;
   localparam int FULL_W  = rldm_pkg::FULL_W;
   localparam int SPLIT   = rldm_pkg::SPLIT;
   localparam int MAG_W   = rldm_pkg::MAG_W;
   localparam int SUM_W   = rldm_pkg::SUM_W;
   localparam int AH_W    = A_W - SPLIT;
   localparam int RH_W    = R2_W - SPLIT;
   localparam int LL_W    = 2 * SPLIT;
   localparam int LH_W    = SPLIT + RH_W;
   localparam int HL_W    = AH_W + SPLIT;
   localparam int HH_W    = AH_W + RH_W;
   localparam int MID_W   = ((AH_W > RH_W) ? AH_W : RH_W) + SPLIT + 1;
   localparam int MIDH_W  = MID_W - SPLIT;
   localparam int LOW_W   = LL_W + 1;
   localparam int HI_W    = FULL_W - LL_W;
   localparam int RSH     = K_FRAC_BITS + rldm_pkg::R2_FRAC - 1;
   localparam int Q_W     = FULL_W - RSH;
   localparam int SIDE_N  = rldm_pkg::MOVE_STAGES - 1;
   localparam logic [MAG_W-1:0] MAG_CLAMP = MAG_W'(1) << (MAG_W - 1);
   localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((2 ** (OUT_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] OUT_MIN = SUM_W'(-(2 ** (OUT_W - 1)));

   // position and sign travel alongside the product
   logic signed [POS_W-1:0] pos_pipe_ff [SIDE_N];
   logic [SIDE_N-1:0]       neg_pipe_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pos_pipe_ff[0] <= pos;
         neg_pipe_ff[0] <= neg;
         for (int i = 1; i < SIDE_N; i++) begin
            pos_pipe_ff[i] <= pos_pipe_ff[i-1];
            neg_pipe_ff[i] <= neg_pipe_ff[i-1];
         end
      end
   end

   // stage 1: four partial products
   logic [LL_W-1:0] ll_ff, ll_in;
   logic [LH_W-1:0] lh_ff, lh_in;
   logic [HL_W-1:0] hl_ff, hl_in;
   logic [HH_W-1:0] hh_ff, hh_in;

   assign ll_in = LL_W'(a[SPLIT-1:0]) * LL_W'(r2[SPLIT-1:0]);
   assign lh_in = LH_W'(a[SPLIT-1:0]) * LH_W'(r2[R2_W-1:SPLIT]);
   assign hl_in = HL_W'(a[A_W-1:SPLIT]) * HL_W'(r2[SPLIT-1:0]);
   assign hh_in = HH_W'(a[A_W-1:SPLIT]) * HH_W'(r2[R2_W-1:SPLIT]);

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         hh_ff <= hh_in;
      end
   end

   // stage 2: sum the cross terms
   logic [MID_W-1:0] mid_ff, mid_in;
   logic [LL_W-1:0]  ll2_ff;
   logic [HH_W-1:0]  hh2_ff;

   assign mid_in = MID_W'(lh_ff) + MID_W'(hl_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         mid_ff <= mid_in;
         ll2_ff <= ll_ff;
         hh2_ff <= hh_ff;
      end
   end

   // stage 3: low half of the product with its carry
   logic [LOW_W-1:0]  low_ff, low_in;
   logic [MIDH_W-1:0] midh_ff;
   logic [HH_W-1:0]   hh3_ff;

   assign low_in = LOW_W'(ll2_ff) + LOW_W'({mid_ff[SPLIT-1:0], {SPLIT{1'b0}}});

   always_ff @(posedge clock) begin
      if (en) begin
         low_ff  <= low_in;
         midh_ff <= mid_ff[MID_W-1:SPLIT];
         hh3_ff  <= hh2_ff;
      end
   end

   // stage 4: high half, full product assembled
   logic [HI_W-1:0]   high_sum;
   logic [FULL_W-1:0] prod_ff, prod_in;

   assign high_sum = HI_W'(hh3_ff) + HI_W'(midh_ff) + HI_W'(low_ff[LL_W]);
   assign prod_in  = {high_sum, low_ff[LL_W-1:0]};

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   // stage 5: round half up at the coefficient point, hold large moves
   logic [Q_W-1:0]   quo;
   logic [Q_W:0]     rnd_sum;
   logic [Q_W-1:0]   mag_full;
   logic             mag_over;
   logic [MAG_W-1:0] mag_ff, mag_in;

   assign quo      = prod_ff[FULL_W-1:RSH];
   assign rnd_sum  = (Q_W + 1)'(quo) + (Q_W + 1)'(1);
   assign mag_full = rnd_sum[Q_W:1];
   assign mag_over = |mag_full[Q_W-1:MAG_W-1];
   assign mag_in   = mag_over ? MAG_CLAMP : mag_full[MAG_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag_in;
      end
   end

   // stage 6: apply the sign, add to the position and saturate
   logic signed [SUM_W-1:0] mv_pos, move, total;
   logic signed [OUT_W-1:0] mapped_ff, mapped_in;
   logic                    clip_ff, clip_in;

   assign mv_pos = signed'(SUM_W'(mag_ff));
   assign move   = neg_pipe_ff[SIDE_N-1] ? -mv_pos : mv_pos;
   assign total  = SUM_W'(pos_pipe_ff[SIDE_N-1]) + move;

   always_comb begin
      if (total > OUT_MAX) begin
         mapped_in = OUT_MAX[OUT_W-1:0];
         clip_in   = 1'b1;
      end else if (total < OUT_MIN) begin
         mapped_in = OUT_MIN[OUT_W-1:0];
         clip_in   = 1'b1;
      end else begin
         mapped_in = total[OUT_W-1:0];
         clip_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mapped_ff <= mapped_in;
         clip_ff   <= clip_in;
      end
   end

   assign mapped = mapped_ff;
   assign clip   = clip_ff;

endmodule

// ----- sv/radial_lens_distortion_map_top.sv -----
// Radial lens distortion map, single coefficient. Takes one pixel coordinate per clock and
// returns one mapped coordinate pair with a saturation flag per item; an item can enter in
// every cycle in which req_stall is low and passes 4 front-end stages for scale, shift and
// centre offset, 2 stages for squares and radius, and 6 stages for the wide move product
// from four partial products of operands split at bit 31, rounding and saturation.
// A result that is stalled moves into a one-entry output skid register, so the input
// stalls only while that register is full. Configuration registers sit on an APB-style
// port at byte address 4*index and should be written only while no item is in flight.
// depends on rldm_pkg, rldm_csr, rldm_axis_front and rldm_axis_move
module radial_lens_distortion_map_top #(
   parameter int COORD_BITS  = 12,
   parameter int K_FRAC_BITS = 40
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [COORD_BITS-1:0]              req_pixel_x,
   input  logic [COORD_BITS-1:0]              req_pixel_y,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [rldm_pkg::OUT_W-1:0]  rsp_mapped_x,
   output logic signed [rldm_pkg::OUT_W-1:0]  rsp_mapped_y,
   output logic                               rsp_clipped,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rldm_pkg::ADDR_W-1:0]        paddr,
   input  logic [rldm_pkg::DATA_W-1:0]        pwdata,
   output logic [rldm_pkg::DATA_W-1:0]        prdata,
   output logic                               pready
);

   localparam int PIX_W   = rldm_pkg::PIX_W;
   localparam int K_W     = rldm_pkg::K_W;
   localparam int POS_W   = rldm_pkg::POS_W;
   localparam int DMAG_W  = rldm_pkg::DMAG_W;
   localparam int SQ_W    = rldm_pkg::SQ_W;
   localparam int R2_W    = rldm_pkg::R2_W;
   localparam int A_W     = rldm_pkg::A_W;
   localparam int OUT_W   = rldm_pkg::OUT_W;
   localparam int STAGES  = rldm_pkg::PIPE_STAGES;

   rldm_pkg::cfg_type cfg;
   logic en;

   // configuration registers
   rldm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // valid bits, one per stage, advancing with the datapath
   logic [STAGES-1:0] valid_ff, valid_in;
   logic              skid_valid_ff, skid_valid_in;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign valid_in  = {valid_ff[STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // front end per axis
   logic signed [POS_W-1:0] pos_x, pos_y;
   logic [DMAG_W-1:0]       dmag_x, dmag_y;
   logic                    dneg_x, dneg_y;

   rldm_axis_front u_front_x (
      .clock    (clock),
      .en       (en),
      .pixel    (PIX_W'(req_pixel_x)),
      .scale_en (cfg.scale_enable),
      .scale    (cfg.x_scale),
      .shift    (cfg.x_shift),
      .centre   (cfg.centre_x),
      .pos      (pos_x),
      .dmag     (dmag_x),
      .dneg     (dneg_x)
   );

   rldm_axis_front u_front_y (
      .clock    (clock),
      .en       (en),
      .pixel    (PIX_W'(req_pixel_y)),
      .scale_en (cfg.scale_enable),
      .scale    (cfg.y_scale),
      .shift    (cfg.y_shift),
      .centre   (cfg.centre_y),
      .pos      (pos_y),
      .dmag     (dmag_y),
      .dneg     (dneg_y)
   );

   // squares, offset times coefficient magnitude, move sign
   logic signed [K_W-1:0]   k_neg_val;
   logic [K_W-1:0]          k_mag;
   logic [SQ_W-1:0]         sq_x_ff, sq_x_in, sq_y_ff, sq_y_in;
   logic [A_W-1:0]          ax_ff, ax_in, ay_ff, ay_in;
   logic                    negx_ff, negx_in, negy_ff, negy_in;
   logic signed [POS_W-1:0] posx1_ff, posy1_ff;

   assign k_neg_val = -cfg.k;
   assign k_mag     = cfg.k[K_W-1] ? k_neg_val : cfg.k;
   assign sq_x_in   = SQ_W'(dmag_x) * SQ_W'(dmag_x);
   assign sq_y_in   = SQ_W'(dmag_y) * SQ_W'(dmag_y);
   assign ax_in     = A_W'(dmag_x) * A_W'(k_mag);
   assign ay_in     = A_W'(dmag_y) * A_W'(k_mag);
   assign negx_in   = dneg_x ^ cfg.k[K_W-1];
   assign negy_in   = dneg_y ^ cfg.k[K_W-1];

   always_ff @(posedge clock) begin
      if (en) begin
         sq_x_ff  <= sq_x_in;
         sq_y_ff  <= sq_y_in;
         ax_ff    <= ax_in;
         ay_ff    <= ay_in;
         negx_ff  <= negx_in;
         negy_ff  <= negy_in;
         posx1_ff <= pos_x;
         posy1_ff <= pos_y;
      end
   end

   // squared radius
   logic [R2_W-1:0]         r2_ff, r2_in;
   logic [A_W-1:0]          ax2_ff, ay2_ff;
   logic                    negx2_ff, negy2_ff;
   logic signed [POS_W-1:0] posx2_ff, posy2_ff;

   assign r2_in = R2_W'(sq_x_ff) + R2_W'(sq_y_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         r2_ff    <= r2_in;
         ax2_ff   <= ax_ff;
         ay2_ff   <= ay_ff;
         negx2_ff <= negx_ff;
         negy2_ff <= negy_ff;
         posx2_ff <= posx1_ff;
         posy2_ff <= posy1_ff;
      end
   end

   // move and saturation per axis
   logic signed [OUT_W-1:0] mapped_x, mapped_y;
   logic                    clip_x, clip_y;

   rldm_axis_move #(.K_FRAC_BITS(K_FRAC_BITS)) u_move_x (
      .clock  (clock),
      .en     (en),
      .a      (ax2_ff),
      .r2     (r2_ff),
      .pos    (posx2_ff),
      .neg    (negx2_ff),
      .mapped (mapped_x),
      .clip   (clip_x)
   );

   rldm_axis_move #(.K_FRAC_BITS(K_FRAC_BITS)) u_move_y (
      .clock  (clock),
      .en     (en),
      .a      (ay2_ff),
      .r2     (r2_ff),
      .pos    (posy2_ff),
      .neg    (negy2_ff),
      .mapped (mapped_y),
      .clip   (clip_y)
   );

   // output skid register catches a stalled item; the pipeline holds while it is full
   logic                    skid_load;
   logic signed [OUT_W-1:0] skid_x_ff, skid_y_ff;
   logic                    skid_clip_ff;

   assign skid_load     = en && valid_ff[STAGES-1] && rsp_stall;
   assign skid_valid_in = skid_valid_ff ? rsp_stall : skid_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_load) begin
         skid_x_ff    <= mapped_x;
         skid_y_ff    <= mapped_y;
         skid_clip_ff <= clip_x | clip_y;
      end
   end

   // result port
   assign rsp_valid    = skid_valid_ff | valid_ff[STAGES-1];
   assign rsp_mapped_x = skid_valid_ff ? skid_x_ff : mapped_x;
   assign rsp_mapped_y = skid_valid_ff ? skid_y_ff : mapped_y;
   assign rsp_clipped  = skid_valid_ff ? skid_clip_ff : (clip_x | clip_y);

endmodule

// ----- sv/rldm_checker.sv -----
// rldm_checker: port-level checks of the radial lens map's flow control
// bound to radial_lens_distortion_map_top; uses rldm_pkg for the result width
module rldm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [rldm_pkg::OUT_W-1:0]  rsp_mapped_x,
   input logic signed [rldm_pkg::OUT_W-1:0]  rsp_mapped_y,
   input logic                               rsp_clipped
);

   // a stalled result stays offered and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_mapped_x)
         && $stable(rsp_mapped_y) && $stable(rsp_clipped)))
      else $error("stalled result item changed or vanished");

   // the input only stalls while a result item is waiting
   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result item offered");

   // input stall only starts after a result item was stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stall raised without an output stall");

   // reset empties the pipeline and the skid register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("items survived reset");

endmodule

bind radial_lens_distortion_map_top rldm_checker u_rldm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_mapped_x (rsp_mapped_x),
   .rsp_mapped_y (rsp_mapped_y),
   .rsp_clipped  (rsp_clipped)
);
